/* sv/rzsd_pkg.sv */
`timescale 1ns / 1ps

package rzsd_pkg;

   localparam int WINDOW_MAX_DEF  = 32;
   localparam int SAMPLE_BITS_DEF = 16;

   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 8;
   localparam int WLEN_W      = 6;
   localparam int THR_W       = 8;
   localparam int THR_SQ_W    = 2 * THR_W;
   // Q4.4 threshold squared carries a scale of 256
   localparam int DEV_SHIFT   = 8;

   localparam logic [CSR_INDEX_W-1:0] CSR_WINDOW_LENGTH = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_THRESHOLD     = 1'd1;

   localparam logic [WLEN_W-1:0] WLEN_RESET = 6'd5;
   localparam logic [THR_W-1:0]  THR_RESET  = 8'd48;

   typedef struct packed {
      logic start;
      logic wide;
   } mac_cmd_type;

endpackage

/* sv/rzsd_ram.sv */
`timescale 1ns / 1ps

module rzsd_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 32,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* sv/rzsd_mac.sv */
`timescale 1ns / 1ps

module rzsd_mac
   import rzsd_pkg::*;
#(
   parameter int A_W = 41,
   parameter int B_W = 22,
   localparam int P_W = A_W + B_W
) (
   input  logic              clock,
   input  logic              reset,
   input  mac_cmd_type       cmd,
   input  logic [A_W-1:0]    a,
   input  logic [B_W-1:0]    b,
   output logic              done,
   output logic [P_W-1:0]    product
);

   localparam int NL    = (A_W + B_W - 1) / B_W;
   localparam int AP_W  = NL * B_W;
   localparam int CNT_W = $clog2(NL + 1);
   localparam int PP_W  = 2 * B_W;

   logic [AP_W-1:0]  a_ff, a_in;
   logic [B_W-1:0]   b_ff, b_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [PP_W-1:0]  pp_ff, pp_in;
   logic             pp_vld_ff, pp_vld_in;
   logic             pp_last_ff, pp_last_in;
   logic [P_W-1:0]   acc_ff, acc_in;
   logic [P_W-1:0]   acc_sum_c;

   // limbs of a go most significant first, Horner style
   assign acc_sum_c = (acc_ff << B_W) + P_W'(pp_ff);
   assign product   = acc_sum_c;
   assign done      = pp_vld_ff && pp_last_ff;

   always_comb begin
      a_in       = a_ff;
      b_in       = b_ff;
      cnt_in     = cnt_ff;
      pp_in      = pp_ff;
      pp_vld_in  = 1'b0;
      pp_last_in = pp_last_ff;
      acc_in     = acc_ff;
      if (cmd.start) begin
         a_in   = cmd.wide ? AP_W'(a) : (AP_W'(a) << (AP_W - B_W));
         b_in   = b;
         cnt_in = cmd.wide ? CNT_W'(NL) : CNT_W'(1);
         acc_in = '0;
      end else begin
         if (cnt_ff != '0) begin
            pp_in      = PP_W'(a_ff[AP_W-1 -: B_W]) * PP_W'(b_ff);
            a_in       = a_ff << B_W;
            cnt_in     = cnt_ff - 1'b1;
            pp_vld_in  = 1'b1;
            pp_last_in = (cnt_ff == CNT_W'(1));
         end
         if (pp_vld_ff) begin
            acc_in = acc_sum_c;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff     <= '0;
         pp_vld_ff  <= 1'b0;
         pp_last_ff <= 1'b0;
      end else begin
         cnt_ff     <= cnt_in;
         pp_vld_ff  <= pp_vld_in;
         pp_last_ff <= pp_last_in;
      end
      a_ff   <= a_in;
      b_ff   <= b_in;
      pp_ff  <= pp_in;
      acc_ff <= acc_in;
   end

   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.start |-> (cnt_ff == '0 && !pp_vld_ff))
      else $error("multiply started while busy");

   a_done_pulse: assert property (@(posedge clock) disable iff (reset)
      done |=> !done)
      else $error("done held longer than one cycle");

   a_pp_source: assert property (@(posedge clock) disable iff (reset)
      pp_vld_ff |-> $past(cnt_ff) != '0)
      else $error("partial product without a pending limb");

endmodule

/* sv/rolling_zscore_spike_detector_core.sv */
`timescale 1ns / 1ps
// channel   dir   handshake                 payload
// req_      in    req_valid / req_stall     req_sample
// rsp_      out   rsp_valid / rsp_stall     rsp_spike, rsp_history_ready
// csr_      in    csr_valid / csr_ready     csr_index, csr_data
//
// One item at a time through one shared limb multiplier. While the window fills only
// the new sample is squared; when the window variance is zero the deviation and
// threshold products are skipped.
// Reset (synchronous) clears the window; history ram contents are not cleared.
// A held result does not block the next item; finishing waits on a stalled result.

module rolling_zscore_spike_detector_core
   import rzsd_pkg::*;
#(
   parameter int WINDOW_MAX  = WINDOW_MAX_DEF,
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [SAMPLE_BITS-1:0] req_sample,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_spike,
   output logic                          rsp_history_ready,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [CSR_INDEX_W-1:0]        csr_index,
   input  logic [CSR_DATA_W-1:0]         csr_data
);

   localparam int SB   = SAMPLE_BITS;
   localparam int WL   = $clog2(WINDOW_MAX);
   localparam int AW   = WL;
   localparam int NW   = $clog2(WINDOW_MAX + 1);
   localparam int S_W  = SB + WL;
   localparam int Q_W  = 2 * SB - 1 + WL;
   localparam int DM_W = SB + WL + 1;
   localparam int DS_W = DM_W + 1;
   localparam int V_W  = 2 * SB - 1 + 2 * WL;
   localparam int X2_W = 2 * SB;
   localparam int A_W  = V_W;
   localparam int B_W  = (DM_W > THR_SQ_W) ? DM_W : THR_SQ_W;
   localparam int P_W  = A_W + B_W;

   typedef enum logic [3:0] {
      ST_IDLE, ST_NX, ST_S2, ST_NQ, ST_D2, ST_MM, ST_MV, ST_X2, ST_O2, ST_UPD
   } state_type;

   state_type               state_ff, state_in;
   logic                    issued_ff, issued_in;
   logic [WLEN_W-1:0]       wlen_ff, wlen_in;
   logic [THR_W-1:0]        thr_ff, thr_in;
   logic [AW-1:0]           wp_ff, wp_in;
   logic [NW-1:0]           seen_ff, seen_in;
   logic signed [S_W-1:0]   sum_ff, sum_in;
   logic [Q_W-1:0]          sq_ff, sq_in;
   logic signed [SB-1:0]    x_ff, x_in;
   logic [NW-1:0]           n_ff, n_in;
   logic                    ready_ff, ready_in;
   logic [DM_W-1:0]         dmag_ff, dmag_in;
   logic [V_W-1:0]          s2_ff, s2_in;
   logic [V_W-1:0]          v_ff, v_in;
   logic [2*DM_W-1:0]       d2_ff, d2_in;
   logic [THR_SQ_W-1:0]     mm_ff, mm_in;
   logic                    spike_ff, spike_in;
   logic [X2_W-1:0]         x2_ff, x2_in;
   logic [X2_W-1:0]         o2_ff, o2_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    rsp_spike_ff, rsp_spike_in;
   logic                    rsp_hist_ff, rsp_hist_in;

   logic                    req_fire, csr_fire, upd_fire;
   logic [NW-1:0]           n_c;
   logic [AW:0]             old_sum_c;
   logic [AW-1:0]           rd_addr_c;
   logic [SB-1:0]           ov_raw;
   logic signed [SB-1:0]    ov_c;
   logic [SB-1:0]           xmag_c, ovmag_c;
   logic [S_W-1:0]          smag_c;
   logic signed [DS_W-1:0]  pm_c, nx_c, d_c;
   logic [V_W-1:0]          v_c;
   mac_cmd_type             mac_cmd;
   logic [A_W-1:0]          mac_a;
   logic [B_W-1:0]          mac_b;
   logic                    mac_done;
   logic [P_W-1:0]          mac_product;

   assign req_stall         = (state_ff != ST_IDLE);
   assign csr_ready         = (state_ff == ST_IDLE);
   assign req_fire          = req_valid && (state_ff == ST_IDLE);
   assign csr_fire          = csr_valid && csr_ready;
   assign upd_fire          = (state_ff == ST_UPD) && (!rsp_valid_ff || !rsp_stall);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_spike         = rsp_spike_ff;
   assign rsp_history_ready = rsp_hist_ff;

   assign ov_c    = ov_raw;
   assign xmag_c  = x_ff[SB-1] ? -x_ff : x_ff;
   assign ovmag_c = ov_c[SB-1] ? -ov_c : ov_c;
   assign smag_c  = sum_ff[S_W-1] ? -sum_ff : sum_ff;

   always_comb begin
      if (wlen_ff == '0) begin
         n_c = NW'(1);
      end else if (32'(wlen_ff) > 32'(WINDOW_MAX)) begin
         n_c = NW'(WINDOW_MAX);
      end else begin
         n_c = NW'(wlen_ff);
      end
      old_sum_c = {1'b0, wp_ff} + (AW+1)'(WINDOW_MAX) - (AW+1)'(n_c);
      if (old_sum_c >= (AW+1)'(WINDOW_MAX)) begin
         rd_addr_c = AW'(old_sum_c - (AW+1)'(WINDOW_MAX));
      end else begin
         rd_addr_c = AW'(old_sum_c);
      end
   end

   always_comb begin
      pm_c = DS_W'(mac_product);
      nx_c = x_ff[SB-1] ? -pm_c : pm_c;
      d_c  = nx_c - DS_W'(sum_ff);
      v_c  = V_W'(mac_product) - s2_ff;
   end

   always_comb begin
      mac_cmd.start = (state_ff inside {ST_NX, ST_S2, ST_NQ, ST_D2, ST_MM, ST_MV,
                                        ST_X2, ST_O2}) && !issued_ff;
      mac_cmd.wide  = 1'b0;
      mac_a         = '0;
      mac_b         = '0;
      case (state_ff)
         ST_NX: begin
            mac_a = A_W'(xmag_c);
            mac_b = B_W'(n_ff);
         end
         ST_S2: begin
            mac_a = A_W'(smag_c);
            mac_b = B_W'(smag_c);
         end
         ST_NQ: begin
            mac_a        = A_W'(sq_ff);
            mac_b        = B_W'(n_ff);
            mac_cmd.wide = 1'b1;
         end
         ST_D2: begin
            mac_a = A_W'(dmag_ff);
            mac_b = B_W'(dmag_ff);
         end
         ST_MM: begin
            mac_a = A_W'(thr_ff);
            mac_b = B_W'(thr_ff);
         end
         ST_MV: begin
            mac_a        = A_W'(v_ff);
            mac_b        = B_W'(mm_ff);
            mac_cmd.wide = 1'b1;
         end
         ST_X2: begin
            mac_a = A_W'(xmag_c);
            mac_b = B_W'(xmag_c);
         end
         ST_O2: begin
            mac_a = A_W'(ovmag_c);
            mac_b = B_W'(ovmag_c);
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      issued_in    = issued_ff;
      wlen_in      = wlen_ff;
      thr_in       = thr_ff;
      wp_in        = wp_ff;
      seen_in      = seen_ff;
      sum_in       = sum_ff;
      sq_in        = sq_ff;
      x_in         = x_ff;
      n_in         = n_ff;
      ready_in     = ready_ff;
      dmag_in      = dmag_ff;
      s2_in        = s2_ff;
      v_in         = v_ff;
      d2_in        = d2_ff;
      mm_in        = mm_ff;
      spike_in     = spike_ff;
      x2_in        = x2_ff;
      o2_in        = o2_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_spike_in = rsp_spike_ff;
      rsp_hist_in  = rsp_hist_ff;

      if (mac_cmd.start) begin
         issued_in = 1'b1;
      end else if (mac_done) begin
         issued_in = 1'b0;
      end

      if (csr_fire) begin
         case (csr_index)
            CSR_WINDOW_LENGTH: begin
               wlen_in = csr_data[WLEN_W-1:0];
               wp_in   = '0;
               seen_in = '0;
               sum_in  = '0;
               sq_in   = '0;
            end
            CSR_THRESHOLD: begin
               thr_in = csr_data[THR_W-1:0];
            end
            default: begin
            end
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               x_in     = req_sample;
               n_in     = n_c;
               ready_in = (seen_ff >= n_c);
               spike_in = 1'b0;
               state_in = (seen_ff >= n_c) ? ST_NX : ST_X2;
            end
         end
         ST_NX: begin
            if (mac_done) begin
               dmag_in  = DM_W'(d_c[DS_W-1] ? -d_c : d_c);
               state_in = ST_S2;
            end
         end
         ST_S2: begin
            if (mac_done) begin
               s2_in    = V_W'(mac_product);
               state_in = ST_NQ;
            end
         end
         ST_NQ: begin
            if (mac_done) begin
               v_in     = v_c;
               state_in = (v_c == '0) ? ST_X2 : ST_D2;
            end
         end
         ST_D2: begin
            if (mac_done) begin
               d2_in    = (2*DM_W)'(mac_product);
               state_in = ST_MM;
            end
         end
         ST_MM: begin
            if (mac_done) begin
               mm_in    = THR_SQ_W'(mac_product);
               state_in = ST_MV;
            end
         end
         ST_MV: begin
            if (mac_done) begin
               spike_in = P_W'({d2_ff, {DEV_SHIFT{1'b0}}}) > mac_product;
               state_in = ST_X2;
            end
         end
         ST_X2: begin
            if (mac_done) begin
               x2_in    = X2_W'(mac_product);
               state_in = ready_ff ? ST_O2 : ST_UPD;
            end
         end
         ST_O2: begin
            if (mac_done) begin
               o2_in    = X2_W'(mac_product);
               state_in = ST_UPD;
            end
         end
         ST_UPD: begin
            if (upd_fire) begin
               sum_in       = sum_ff + S_W'(x_ff) - (ready_ff ? S_W'(ov_c) : S_W'(0));
               sq_in        = sq_ff + Q_W'(x2_ff) - (ready_ff ? Q_W'(o2_ff) : Q_W'(0));
               wp_in        = (wp_ff == AW'(WINDOW_MAX - 1)) ? '0 : wp_ff + 1'b1;
               seen_in      = (seen_ff < NW'(WINDOW_MAX)) ? seen_ff + 1'b1 : seen_ff;
               rsp_valid_in = 1'b1;
               rsp_spike_in = spike_ff;
               rsp_hist_in  = ready_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         issued_ff    <= 1'b0;
         wlen_ff      <= WLEN_RESET;
         thr_ff       <= THR_RESET;
         wp_ff        <= '0;
         seen_ff      <= '0;
         sum_ff       <= '0;
         sq_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         issued_ff    <= issued_in;
         wlen_ff      <= wlen_in;
         thr_ff       <= thr_in;
         wp_ff        <= wp_in;
         seen_ff      <= seen_in;
         sum_ff       <= sum_in;
         sq_ff        <= sq_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      x_ff         <= x_in;
      n_ff         <= n_in;
      ready_ff     <= ready_in;
      dmag_ff      <= dmag_in;
      s2_ff        <= s2_in;
      v_ff         <= v_in;
      d2_ff        <= d2_in;
      mm_ff        <= mm_in;
      spike_ff     <= spike_in;
      x2_ff        <= x2_in;
      o2_ff        <= o2_in;
      rsp_spike_ff <= rsp_spike_in;
      rsp_hist_ff  <= rsp_hist_in;
   end

   rzsd_ram #(
      .WIDTH (SB),
      .DEPTH (WINDOW_MAX)
   ) u_history (
      .clock   (clock),
      .wr_en   (upd_fire),
      .wr_addr (wp_ff),
      .wr_data (x_ff),
      .rd_en   (req_fire),
      .rd_addr (rd_addr_c),
      .rd_data (ov_raw)
   );

   rzsd_mac #(
      .A_W (A_W),
      .B_W (B_W)
   ) u_mac (
      .clock   (clock),
      .reset   (reset),
      .cmd     (mac_cmd),
      .a       (mac_a),
      .b       (mac_b),
      .done    (mac_done),
      .product (mac_product)
   );

   a_seen_bound: assert property (@(posedge clock) disable iff (reset)
      32'(seen_ff) <= WINDOW_MAX)
      else $error("sample count beyond window maximum");

   a_wp_bound: assert property (@(posedge clock) disable iff (reset)
      32'(wp_ff) < WINDOW_MAX)
      else $error("write position out of ring");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("item accepted without entering the sequence");

   a_spike_needs_history: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_spike) |-> rsp_history_ready)
      else $error("spike flagged without full window");

   a_done_issued: assert property (@(posedge clock) disable iff (reset)
      mac_done |-> issued_ff)
      else $error("multiply result with no request outstanding");

endmodule
